// ===== src/heq_pkg.sv =====
// Shared types and constants for the histogram equalizer.
// Holds the controller state enum and the command/status structs.
// No dependencies.
`default_nettype none
package heq_pkg;

   localparam int LEVELS     = 256;
   localparam int PIX_W      = 8;
   localparam int BIN_W      = 19;
   localparam int NUM_W      = 34;
   localparam int DEN_W      = 28;

   localparam logic [BIN_W-1:0] MAX_FRAME     = 19'd262144;
   localparam logic [BIN_W-1:0] FRAME_RESET   = 19'd262144;
   localparam logic [PIX_W-1:0] FULL_SCALE    = 8'd255;
   localparam logic [PIX_W-1:0] LAST_LEVEL    = PIX_W'(LEVELS - 1);

   localparam logic ACT_COUNT = 1'b0;
   localparam logic ACT_MAP   = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_B_RD,
      ST_B_ACC,
      ST_B_STEP,
      ST_M_RD,
      ST_M_OUT
   } heq_state_type;

   typedef struct packed {
      logic load_item;
      logic sel_idx;
      logic bin_wr;
      logic bin_zero;
      logic idx_clr;
      logic idx_inc;
      logic build_init;
      logic acc;
      logic step;
      logic map_wr;
      logic rsp_load;
   } heq_cmd_type;

   typedef struct packed {
      logic item_last;
      logic idx_last;
      logic step_ok;
      logic rsp_free;
   } heq_sts_type;

endpackage
`default_nettype wire

// ===== src/heq_ctrl.sv =====
// Controller state machine for the histogram equalizer.
// Sequences counting, table build, lookup and histogram clear.
// Depends on heq_pkg.
`default_nettype none
module heq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_stall,
   output heq_pkg::heq_cmd_type      cmd,
   input  wire heq_pkg::heq_sts_type sts
);
   import heq_pkg::*;

   heq_state_type state_ff, state_in;
   logic          map_built_ff, map_built_in;
   logic          accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         map_built_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_built_ff <= map_built_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      map_built_in = map_built_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sel_idx  = 1'b1;
            cmd.bin_wr   = 1'b1;
            cmd.bin_zero = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               if (req_action == ACT_COUNT) begin
                  state_in = ST_CNT_RD;
               end else if (map_built_ff) begin
                  state_in = ST_M_RD;
               end else begin
                  cmd.build_init = 1'b1;
                  state_in       = ST_B_RD;
               end
            end
         end
         ST_CNT_RD: begin
            state_in = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.bin_wr   = 1'b1;
            map_built_in = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_B_RD: begin
            cmd.sel_idx = 1'b1;
            state_in    = ST_B_ACC;
         end
         ST_B_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_B_STEP;
         end
         ST_B_STEP: begin
            if (sts.step_ok) begin
               cmd.step = 1'b1;
            end else begin
               cmd.map_wr = 1'b1;
               if (sts.idx_last) begin
                  cmd.idx_clr  = 1'b1;
                  map_built_in = 1'b1;
                  state_in     = ST_M_RD;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_B_RD;
               end
            end
         end
         ST_M_RD: begin
            state_in = ST_M_OUT;
         end
         ST_M_OUT: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (sts.item_last) begin
                  cmd.idx_clr  = 1'b1;
                  map_built_in = 1'b0;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_count_reads: assert property (@(posedge clock) disable iff (reset)
      accept && (req_action == ACT_COUNT) |=> state_ff == ST_CNT_RD)
      else $error("count item did not start a bin read");

   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && sts.idx_last |=> state_ff == ST_IDLE)
      else $error("clear pass did not end at last bin");

   a_built_from_build: assert property (@(posedge clock) disable iff (reset)
      $rose(map_built_ff) |-> $past(state_ff) == ST_B_STEP)
      else $error("table marked built outside of a build");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded over a waiting item");

endmodule
`default_nettype wire

// ===== src/heq_dp.sv =====
// Datapath for the histogram equalizer: histogram and table memories,
// cumulative level stepper, frame size register and result register.
// Depends on heq_pkg.
`default_nettype none
module heq_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire heq_pkg::heq_cmd_type cmd,
   output heq_pkg::heq_sts_type      sts,
   input  wire logic                 csr_wr_en,
   input  wire logic [18:0]          csr_wr_data,
   input  wire logic                 req_pixel_bit_unused_guard,
   input  wire logic [7:0]           req_pixel,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_mapped_pixel,
   output logic                      rsp_frame_end
);
   import heq_pkg::*;

   logic [BIN_W-1:0] bin_mem [LEVELS];
   logic [PIX_W-1:0] map_mem [LEVELS];

   logic [BIN_W-1:0] frame_ff;
   logic [BIN_W-1:0] divisor;
   logic [PIX_W-1:0] pixel_ff;
   logic             last_ff;
   logic [PIX_W-1:0] idx_ff;
   logic [PIX_W-1:0] addr;
   logic [BIN_W-1:0] bin_rd_ff;
   logic [BIN_W-1:0] bin_inc;
   logic [BIN_W-1:0] bin_wr_data;
   logic [PIX_W-1:0] map_rd_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] bin_scaled;
   logic [DEN_W-1:0] den_ff;
   logic [PIX_W-1:0] q_ff;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] mapped_ff;
   logic             frame_end_ff;

   assign divisor     = (frame_ff == '0) ? BIN_W'(1) : frame_ff;
   assign addr        = cmd.sel_idx ? idx_ff : pixel_ff;
   assign bin_inc     = (bin_rd_ff >= MAX_FRAME) ? bin_rd_ff : bin_rd_ff + BIN_W'(1);
   assign bin_wr_data = cmd.bin_zero ? '0 : bin_inc;
   assign bin_scaled  = ({{(NUM_W-BIN_W-8){1'b0}}, bin_rd_ff, 8'd0})
                      - {{(NUM_W-BIN_W){1'b0}}, bin_rd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_RESET;
      end else if (csr_wr_en) begin
         frame_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         pixel_ff <= req_pixel;
         last_ff  <= req_last && req_pixel_bit_unused_guard;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + PIX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bin_wr) begin
         bin_mem[addr] <= bin_wr_data;
      end
      bin_rd_ff <= bin_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         map_mem[idx_ff] <= q_ff;
      end
      map_rd_ff <= map_mem[pixel_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         num_ff <= '0;
         den_ff <= DEN_W'(divisor);
         q_ff   <= '0;
      end else begin
         if (cmd.acc) begin
            num_ff <= num_ff + bin_scaled;
         end
         if (cmd.step) begin
            den_ff <= den_ff + DEN_W'(divisor);
            q_ff   <= q_ff + PIX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         mapped_ff    <= map_rd_ff;
         frame_end_ff <= last_ff;
      end
   end

   assign sts.item_last = last_ff;
   assign sts.idx_last  = (idx_ff == LAST_LEVEL);
   assign sts.step_ok   = (q_ff != FULL_SCALE)
                        && (num_ff >= {{(NUM_W-DEN_W){1'b0}}, den_ff});
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = mapped_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule
`default_nettype wire

// ===== src/histogram_equalizer_8bit.sv =====
// Histogram equalizer top level: a count item passes CNT_RD and CNT_WR; a map item
// with a built table passes M_RD and M_OUT, its result loaded when rsp_free is set.
// The first map item after counting, reset or a frame end first builds the table:
// read, accumulate, step per bin, levels stepped by the shared compare/add unit.
// The map item marked last starts a histogram clear, one bin a cycle.
// Reset is synchronous and also starts the clear; no item is taken then.
`default_nettype none
module histogram_equalizer_8bit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [18:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_pixel,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_mapped_pixel,
   output logic             rsp_frame_end
);
   import heq_pkg::*;

   heq_cmd_type cmd;
   heq_sts_type sts;
   logic        map_item;

   assign map_item = (req_action == ACT_MAP);

   heq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   heq_dp u_dp (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .sts                        (sts),
      .csr_wr_en                  (csr_wr_en),
      .csr_wr_data                (csr_wr_data),
      .req_pixel_bit_unused_guard (map_item),
      .req_pixel                  (req_pixel),
      .req_last                   (req_last),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_mapped_pixel           (rsp_mapped_pixel),
      .rsp_frame_end              (rsp_frame_end)
   );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for histogram_equalizer_8bit: count and map items through the req/rsp ports,
// with a local histogram and lookup-table model predicting every unpinned mapped pixel.
// Depends on heq_pkg and the histogram_equalizer_8bit RTL.
module tb_top;
   import heq_pkg::*;

   localparam int RANDOM_ITEMS   = 1025;
   localparam int SETTLE_CYCLES  = 320;
   localparam int CYCLE_LIMIT    = 5_000_000;
   localparam int FRAME_SIZE_MAX = 2**BIN_W - 1;

   typedef enum logic {ROW_PIXEL, ROW_FRAME_SIZE} row_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] mapped;
      logic             frame_end;
   } mapped_result_type;

   typedef struct packed {
      logic              pinned;
      mapped_result_type value;
   } pinned_result_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              act;
      logic [PIX_W-1:0]  px;
      logic              lst;
      pinned_result_type tag;
      logic [BIN_W-1:0]  size;
   } stimulus_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [BIN_W-1:0] csr_wr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_action = ACT_COUNT;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [PIX_W-1:0] rsp_mapped_pixel;
   logic             rsp_frame_end;

   logic [BIN_W-1:0] hist_bins [LEVELS];
   logic [PIX_W-1:0] level_lut [LEVELS];
   logic             lut_ready;
   logic [BIN_W-1:0] frame_size;

   mapped_result_type mapped_q [$];
   pinned_result_type pin_q [$];
   stimulus_row_type  directed_rows [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit steady_sender = 1'b0;
   int stall_tick = 0;
   int stall_mode = 0;

   histogram_equalizer_8bit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_pixel        (req_pixel),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_pixel (rsp_mapped_pixel),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_bins();
      int v;
      for (v = 0; v < LEVELS; v++) hist_bins[v] = '0;
   endfunction

   function automatic void build_level_map();
      longint unsigned running;
      longint unsigned quotient;
      longint unsigned divisor;
      int v;
      divisor = (frame_size == 0) ? 1 : frame_size;
      running = 0;
      for (v = 0; v < LEVELS; v++) begin
         running = running + hist_bins[v];
         quotient = (running * FULL_SCALE) / divisor;
         level_lut[v] = (quotient > FULL_SCALE) ? FULL_SCALE : quotient[PIX_W-1:0];
      end
      lut_ready = 1'b1;
   endfunction

   function automatic void equalize_item(input logic act, input logic [PIX_W-1:0] px,
                                         input logic lst, output bit produced,
                                         output mapped_result_type res);
      produced = 1'b0;
      res = '0;
      if (act == ACT_COUNT) begin
         if (hist_bins[px] < MAX_FRAME) hist_bins[px] = hist_bins[px] + 1'b1;
         lut_ready = 1'b0;
      end else begin
         if (!lut_ready) build_level_map();
         res.mapped = level_lut[px];
         res.frame_end = lst;
         produced = 1'b1;
         if (lst) begin
            clear_bins();
            lut_ready = 1'b0;
         end
      end
   endfunction

   function automatic void report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endfunction

   function automatic void add_pixel(input logic act, input logic [PIX_W-1:0] px,
                                     input logic lst, input logic pinned,
                                     input logic [PIX_W-1:0] mapped, input logic fend);
      stimulus_row_type row;
      row = '0;
      row.kind = ROW_PIXEL;
      row.act = act;
      row.px = px;
      row.lst = lst;
      row.tag.pinned = pinned;
      row.tag.value.mapped = mapped;
      row.tag.value.frame_end = fend;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_frame_size(input logic [BIN_W-1:0] size);
      stimulus_row_type row;
      row = '0;
      row.kind = ROW_FRAME_SIZE;
      row.size = size;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [PIX_W-1:0] pick_level(input bit narrow, input int base,
                                                   input int spread);
      int raw;
      if (narrow) raw = base + $urandom_range(0, spread);
      else raw = $urandom_range(0, 255);
      return raw[PIX_W-1:0];
   endfunction

   task automatic drive_pixel(input logic act, input logic [PIX_W-1:0] px, input logic lst,
                              input pinned_result_type tag);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = steady_sender ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      pin_q.push_back(tag);
      req_valid  <= 1'b1;
      req_action <= act;
      req_pixel  <= px;
      req_last   <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input logic [BIN_W-1:0] size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   always @(posedge clock) begin : scoreboard
      pinned_result_type tag;
      mapped_result_type res;
      mapped_result_type want;
      bit produced;
      if (reset) begin
         clear_bins();
         lut_ready = 1'b0;
         frame_size = FRAME_RESET;
      end else begin
         if (csr_wr_en) frame_size = csr_wr_data;
         if (req_valid && !req_stall) begin
            tag = pin_q.pop_front();
            equalize_item(req_action, req_pixel, req_last, produced, res);
            if (produced) begin
               if (tag.pinned) res = tag.value;
               mapped_q.push_back(res);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (mapped_q.size() == 0) begin
               mismatch_count++;
               $error("unexpected item: mapped_pixel %0d frame_end %0d",
                      rsp_mapped_pixel, rsp_frame_end);
            end else begin
               want = mapped_q.pop_front();
               if (rsp_mapped_pixel !== want.mapped)
                  report_mismatch("mapped_pixel", want.mapped, rsp_mapped_pixel);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", want.frame_end, rsp_frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_tick <= 0;
         stall_mode <= 0;
      end else begin
         stall_tick <= stall_tick + 1;
         if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ((stall_tick % 7) < 3);
            default: rsp_stall <= ((stall_tick % 32) < 20);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      stimulus_row_type  row;
      pinned_result_type free_tag;
      logic [BIN_W-1:0] size;
      int sent;
      int n_count;
      int n_map;
      int base;
      int spread;
      int i;
      bit narrow;
      logic lst;
      free_tag = '0;

      // empty histogram maps to zero
      add_pixel(ACT_MAP,   8'd0,   1'b0, 1'b1, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd255, 1'b1, 1'b1, 8'd0,   1'b1);
      add_frame_size(19'd1);
      add_pixel(ACT_COUNT, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd0,   1'b0, 1'b1, 8'd255, 1'b0);
      add_pixel(ACT_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b1);
      // zero frame size divides by one
      add_frame_size(19'd0);
      add_pixel(ACT_COUNT, 8'd128, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd127, 1'b0, 1'b1, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd128, 1'b1, 1'b1, 8'd255, 1'b1);
      add_frame_size(19'd4);
      add_pixel(ACT_COUNT, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_COUNT, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_COUNT, 8'd85,  1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_COUNT, 8'd170, 1'b1, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd0,   1'b0, 1'b1, 8'd63,  1'b0);
      add_pixel(ACT_MAP,   8'd85,  1'b0, 1'b1, 8'd127, 1'b0);
      // count while mapping forces a rebuild
      add_pixel(ACT_COUNT, 8'd85,  1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd85,  1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd255, 1'b1, 1'b1, 8'd255, 1'b1);
      add_frame_size(19'd2);
      add_pixel(ACT_COUNT, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_COUNT, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_COUNT, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd199, 1'b0, 1'b1, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd200, 1'b1, 1'b1, 8'd255, 1'b1);
      add_frame_size(19'h7FFFF);
      add_pixel(ACT_COUNT, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0);
      add_pixel(ACT_MAP,   8'd255, 1'b1, 1'b1, 8'd0,   1'b1);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_FRAME_SIZE) begin
            settle();
            write_frame_size(row.size);
         end else begin
            drive_pixel(row.act, row.px, row.lst, row.tag);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady_sender = ($urandom_range(0, 3) == 0);
         n_count = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
         n_map   = $urandom_range(1, 24);
         narrow  = ($urandom_range(0, 1) == 1);
         base    = $urandom_range(0, 255);
         spread  = $urandom_range(0, 31);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 7))
               0, 1, 2, 3: size = BIN_W'(n_count);
               4: size = BIN_W'($urandom_range(1, n_count));
               5: size = '0;
               6: size = BIN_W'($urandom_range(0, FRAME_SIZE_MAX));
               default: size = FRAME_RESET;
            endcase
            settle();
            write_frame_size(size);
         end
         if ($urandom_range(0, 4) != 0) begin
            for (i = 0; i < n_count; i++) begin
               lst = (i == n_count - 1) && ($urandom_range(0, 1) == 1);
               drive_pixel(ACT_COUNT, pick_level(narrow, base, spread), lst, free_tag);
            end
            for (i = 0; i < n_map; i++)
               drive_pixel(ACT_MAP, pick_level(narrow, base, spread), i == n_map - 1,
                           free_tag);
         end else begin
            for (i = 0; i < n_count + n_map; i++)
               drive_pixel($urandom_range(0, 1) ? ACT_MAP : ACT_COUNT,
                           PIX_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                           free_tag);
         end
         sent += n_count + n_map;
      end

      settle();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
